FILE: rtl/sbsa_pkg.sv
// ----------------------------------------------------------------------------
// Stream buffer slot allocator package
// Widths, command and status codes, and the structs that travel between the
// sequencer and the slot cells.
// ----------------------------------------------------------------------------
package sbsa_pkg;

   localparam int SLOT_COUNT  = 64;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ID_W        = 8;
   localparam int ADDR_W      = 25;
   localparam int LEN_W       = ADDR_W + 1;
   localparam int IDX_OUT_W   = 6;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 8;

   localparam logic [ADDR_W-1:0] MEMORY_BYTES = ADDR_W'(16 * 1024 * 1024);
   localparam logic [ADDR_W-1:0] FLOOR_RESET  = ADDR_W'(640 * 2);
   localparam logic [ADDR_W-1:0] TOP_RESET    = ADDR_W'(16777216);
   localparam logic [LEN_W-1:0]  ROUND_MASK   = LEN_W'(31);
   localparam logic [ID_W:0]     SLOT_LIMIT   = (ID_W + 1)'(SLOT_COUNT);

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REINIT = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_ID   = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_STREAM_TOP   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOOR_OFFSET = 8'd1;

   // Command as held by the sequencer for the duration of one transaction.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [LEN_W-1:0]  length;
      logic [ID_W-1:0]   slot_id;
   } op_type;

   // Search wave that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic              go;
      logic              hit;
      logic [SLOT_W-1:0] hit_idx;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] length;
      logic              free_seen;
      logic [SLOT_W-1:0] free_idx;
   } wave_type;

   // Broadcast write of a freshly carved block into one slot.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] length;
   } commit_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [IDX_OUT_W-1:0] slot_index;
      logic [ADDR_W-1:0]    block_address;
      logic [ADDR_W-1:0]    block_length;
   } result_type;

endpackage

FILE: rtl/sbsa_if.sv
// ----------------------------------------------------------------------------
// Stream buffer slot allocator channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbsa_req_if;
   logic                         valid;
   logic                         ready;
   logic [sbsa_pkg::CMD_W-1:0]   cmd;
   logic [sbsa_pkg::ADDR_W-1:0]  request_length;
   logic [sbsa_pkg::ID_W-1:0]    slot_id;

   modport source (output valid, cmd, request_length, slot_id, input ready);
   modport sink   (input valid, cmd, request_length, slot_id, output ready);
endinterface

interface sbsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sbsa_pkg::STATUS_W-1:0]  status;
   logic [sbsa_pkg::IDX_OUT_W-1:0] slot_index;
   logic [sbsa_pkg::ADDR_W-1:0]    block_address;
   logic [sbsa_pkg::ADDR_W-1:0]    block_length;

   modport source (output valid, status, slot_index, block_address, block_length,
                   input ready);
   modport sink   (input valid, status, slot_index, block_address, block_length,
                   output ready);
endinterface

interface sbsa_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sbsa_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [sbsa_pkg::ADDR_W-1:0]      write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

FILE: rtl/stream_buffer_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Stream buffer slot allocator
// Slot table that carves audio memory blocks downward from a stream pointer.
//
//   Channel   Dir  Handshake      Payload
//   req_bus   in   valid/ready    cmd, request_length, slot_id
//   rsp_bus   out  valid/ready    status, slot_index, block_address, block_length
//   csr_bus   in   valid/ready    reg_index, write_data (always ready)
//
// Allocate, and free and query with a valid slot id, send a search wave down
// the chain of slot cells, one cell per cycle, before the response is built.
// Reinitialize and an invalid slot id skip the wave and go straight to the response.
// One transaction is in flight at a time; the next request can be taken once
// the response is loaded, while it still waits in the output register.
// Reset clears the table at once and loads the stream pointer with the top.
// ----------------------------------------------------------------------------
module stream_buffer_slot_allocator_core (
   input  logic        clock,
   input  logic        reset,
   sbsa_req_if.sink    req_bus,
   sbsa_rsp_if.source  rsp_bus,
   sbsa_csr_if.sink    csr_bus
);
   import sbsa_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SWEEP = 2'd1;
   localparam logic [1:0] S_DONE  = 2'd2;

   logic [1:0]        state_ff, state_in;
   op_type            op_ff, op_in;
   logic              start_ff, start_in;
   logic [ADDR_W-1:0] stream_top_ff;
   logic [ADDR_W-1:0] floor_ff;
   logic [ADDR_W-1:0] sp_ff, sp_in;
   result_type        res_ff, res_in;
   result_type        rsp_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load_rsp;
   logic              clear;
   commit_type        commit;
   wave_type          wave_chain [SLOT_COUNT+1];
   wave_type          wave_end;
   logic              req_fire;
   logic [LEN_W-1:0]  len_rounded;
   logic [ADDR_W-1:0] eff_top;
   logic [ADDR_W-1:0] eff_floor;
   logic [LEN_W-1:0]  new_base;
   logic              space_ok;

   assign req_fire    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign len_rounded = ({1'b0, req_bus.request_length} + ROUND_MASK) & ~ROUND_MASK;

   // Zero or anything at or above the memory size selects the whole memory.
   assign eff_top   = (stream_top_ff == '0 || stream_top_ff >= MEMORY_BYTES) ?
                      MEMORY_BYTES : stream_top_ff;
   assign eff_floor = (floor_ff == '0) ? ADDR_W'(1) : floor_ff;

   assign new_base = {1'b0, sp_ff} - op_ff.length;
   assign space_ok = ({1'b0, sp_ff} >= op_ff.length) && (new_base >= {1'b0, eff_floor});

   always_comb begin
      wave_chain[0]    = '0;
      wave_chain[0].go = start_ff;
   end
   assign wave_end = wave_chain[SLOT_COUNT];

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      sbsa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (SLOT_W'(i)),
         .op       (op_ff),
         .clear    (clear),
         .commit   (commit),
         .wave_in  (wave_chain[i]),
         .wave_out (wave_chain[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      start_in = 1'b0;
      sp_in    = sp_ff;
      res_in   = res_ff;
      clear    = 1'b0;
      commit   = '0;
      load_rsp = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in.cmd     = req_bus.cmd;
               op_in.length  = len_rounded;
               op_in.slot_id = req_bus.slot_id;
               res_in        = '0;
               case (req_bus.cmd)
                  CMD_REINIT: begin
                     clear    = 1'b1;
                     sp_in    = eff_top;
                     state_in = S_DONE;
                  end
                  CMD_FREE, CMD_QUERY: begin
                     if ({1'b0, req_bus.slot_id} >= SLOT_LIMIT) begin
                        res_in.status = ST_BAD_ID;
                        state_in      = S_DONE;
                     end else begin
                        start_in = 1'b1;
                        state_in = S_SWEEP;
                     end
                  end
                  default: begin
                     start_in = 1'b1;
                     state_in = S_SWEEP;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            if (wave_end.go) begin
               res_in   = '0;
               state_in = S_DONE;
               case (op_ff.cmd)
                  CMD_QUERY: begin
                     res_in.block_address = wave_end.base;
                     res_in.block_length  = wave_end.length;
                  end
                  CMD_ALLOC: begin
                     if (wave_end.hit) begin
                        res_in.slot_index    = IDX_OUT_W'(wave_end.hit_idx);
                        res_in.block_address = wave_end.base;
                        res_in.block_length  = wave_end.length;
                     end else if (wave_end.free_seen) begin
                        // Only the first never-used slot is offered a new block.
                        if (space_ok) begin
                           commit.en            = 1'b1;
                           commit.idx           = wave_end.free_idx;
                           commit.base          = new_base[ADDR_W-1:0];
                           commit.length        = op_ff.length[ADDR_W-1:0];
                           sp_in                = new_base[ADDR_W-1:0];
                           res_in.slot_index    = IDX_OUT_W'(wave_end.free_idx);
                           res_in.block_address = new_base[ADDR_W-1:0];
                           res_in.block_length  = op_ff.length[ADDR_W-1:0];
                        end else begin
                           res_in.status = ST_NO_SPACE;
                        end
                     end else begin
                        res_in.status = ST_NO_SLOT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         stream_top_ff <= TOP_RESET;
         floor_ff      <= FLOOR_RESET;
         sp_ff         <= MEMORY_BYTES;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               CSR_STREAM_TOP:   stream_top_ff <= csr_bus.write_data;
               CSR_FLOOR_OFFSET: floor_ff      <= csr_bus.write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      res_ff <= res_in;
      if (load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_data_ff.status;
   assign rsp_bus.slot_index    = rsp_data_ff.slot_index;
   assign rsp_bus.block_address = rsp_data_ff.block_address;
   assign rsp_bus.block_length  = rsp_data_ff.block_length;

endmodule

FILE: rtl/sbsa_cell.sv
// ----------------------------------------------------------------------------
// Stream buffer slot cell
// Holds one slot's block base, reserved size, length and busy flag, and acts
// on the search wave as it passes through on its way to the next cell.
// ----------------------------------------------------------------------------
module sbsa_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [sbsa_pkg::SLOT_W-1:0] cell_idx,
   input  sbsa_pkg::op_type           op,
   input  logic                       clear,
   input  sbsa_pkg::commit_type       commit,
   input  sbsa_pkg::wave_type         wave_in,
   output sbsa_pkg::wave_type         wave_out
);
   import sbsa_pkg::*;

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] reserved_ff, reserved_in;
   logic [ADDR_W-1:0] length_ff, length_in;
   logic              busy_ff, busy_in;
   wave_type          wave_ff, wave_in_d;
   logic              id_match;
   logic              can_reuse;

   assign id_match  = (op.slot_id[SLOT_W-1:0] == cell_idx);
   assign can_reuse = !busy_ff && (base_ff != '0) && ({1'b0, reserved_ff} >= op.length);

   always_comb begin
      base_in     = base_ff;
      reserved_in = reserved_ff;
      length_in   = length_ff;
      busy_in     = busy_ff;
      wave_in_d   = wave_in;

      if (wave_in.go) begin
         case (op.cmd)
            CMD_ALLOC: begin
               // The first idle slot that already owns a big enough block claims the request.
               if (!wave_in.hit && can_reuse) begin
                  busy_in          = 1'b1;
                  length_in        = op.length[ADDR_W-1:0];
                  wave_in_d.hit     = 1'b1;
                  wave_in_d.hit_idx = cell_idx;
                  wave_in_d.base    = base_ff;
                  wave_in_d.length  = op.length[ADDR_W-1:0];
               end
               if (!wave_in.free_seen && base_ff == '0) begin
                  wave_in_d.free_seen = 1'b1;
                  wave_in_d.free_idx  = cell_idx;
               end
            end
            CMD_FREE: begin
               if (id_match) begin
                  busy_in = 1'b0;
               end
            end
            CMD_QUERY: begin
               if (id_match) begin
                  wave_in_d.hit    = 1'b1;
                  wave_in_d.base   = base_ff;
                  wave_in_d.length = length_ff;
               end
            end
            default: ;
         endcase
      end

      if (commit.en && commit.idx == cell_idx) begin
         base_in     = commit.base;
         reserved_in = commit.length;
         length_in   = commit.length;
         busy_in     = 1'b1;
      end

      if (clear) begin
         base_in     = '0;
         reserved_in = '0;
         length_in   = '0;
         busy_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         reserved_ff <= '0;
         length_ff   <= '0;
         busy_ff     <= 1'b0;
         wave_ff     <= '0;
      end else begin
         base_ff     <= base_in;
         reserved_ff <= reserved_in;
         length_ff   <= length_in;
         busy_ff     <= busy_in;
         wave_ff     <= wave_in_d;
      end
   end

   assign wave_out = wave_ff;

endmodule

FILE: tb/sbsa_slot_table_checker.sv
// ----------------------------------------------------------------------------
// Stream buffer slot allocator checker
// Watches the request, response and register channels, keeps its own copy of
// the slot table and the registers, predicts one response per accepted
// request and compares every accepted response, field by field, in order.
// ----------------------------------------------------------------------------
module sbsa_slot_table_checker (
   input  logic clock,
   input  logic reset,
   sbsa_req_if  req_mon,
   sbsa_rsp_if  rsp_mon,
   sbsa_csr_if  csr_mon,
   output int   error_count,
   output int   outstanding
);
   import sbsa_pkg::*;

   logic [ADDR_W-1:0] top_reg;
   logic [ADDR_W-1:0] floor_reg;
   logic [ADDR_W-1:0] carve_ptr;
   logic [ADDR_W-1:0] blk_base     [SLOT_COUNT];
   logic [ADDR_W-1:0] blk_reserved [SLOT_COUNT];
   logic [ADDR_W-1:0] blk_length   [SLOT_COUNT];
   logic              blk_busy     [SLOT_COUNT];

   result_type awaited_results [$];
   int         mismatches;

   function automatic void clear_slot_table();
      // Zero or anything at or above the memory size selects the whole memory.
      carve_ptr = (top_reg == '0 || top_reg >= MEMORY_BYTES) ? MEMORY_BYTES : top_reg;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         blk_base[i]     = '0;
         blk_reserved[i] = '0;
         blk_length[i]   = '0;
         blk_busy[i]     = 1'b0;
      end
   endfunction

   function automatic result_type predict_step(input logic [CMD_W-1:0]  op,
                                               input logic [ADDR_W-1:0] req_len,
                                               input logic [ID_W-1:0]   id);
      result_type        res;
      logic [LEN_W-1:0]  rounded;
      logic [ADDR_W-1:0] lowest;
      int                pick;
      res  = '0;
      pick = -1;
      case (op)
         CMD_ALLOC: begin
            rounded = (LEN_W'(req_len) + ROUND_MASK) & ~ROUND_MASK;
            lowest  = (floor_reg == '0) ? ADDR_W'(1) : floor_reg;
            // An idle slot that already owns a large enough block wins first.
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (pick < 0 && !blk_busy[i] && blk_base[i] != '0 &&
                   LEN_W'(blk_reserved[i]) >= rounded)
                  pick = i;
            end
            if (pick >= 0) begin
               blk_length[pick] = rounded[ADDR_W-1:0];
            end else begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (pick < 0 && blk_base[i] == '0)
                     pick = i;
               end
               if (pick < 0) begin
                  res.status = ST_NO_SLOT;
               end else if (LEN_W'(carve_ptr) < rounded ||
                            LEN_W'(carve_ptr) - rounded < LEN_W'(lowest)) begin
                  // Only the first unused slot is tried.
                  res.status = ST_NO_SPACE;
                  pick = -1;
               end else begin
                  carve_ptr          = carve_ptr - rounded[ADDR_W-1:0];
                  blk_base[pick]     = carve_ptr;
                  blk_reserved[pick] = rounded[ADDR_W-1:0];
                  blk_length[pick]   = rounded[ADDR_W-1:0];
               end
            end
            if (pick >= 0) begin
               blk_busy[pick]    = 1'b1;
               res.status        = ST_OK;
               res.slot_index    = IDX_OUT_W'(pick);
               res.block_address = blk_base[pick];
               res.block_length  = blk_length[pick];
            end
         end
         CMD_FREE, CMD_QUERY: begin
            if (int'(id) >= SLOT_COUNT) begin
               res.status = ST_BAD_ID;
            end else if (op == CMD_FREE) begin
               blk_busy[id] = 1'b0;
            end else begin
               res.block_address = blk_base[id];
               res.block_length  = blk_length[id];
            end
         end
         default: begin
            clear_slot_table();
         end
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         top_reg   = TOP_RESET;
         floor_reg = FLOOR_RESET;
         clear_slot_table();
         awaited_results.delete();
         mismatches = 0;
         error_count <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               $error("response transaction with no request waiting for it");
            end else begin
               want = awaited_results.pop_front();
               check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_mon.status));
               check_field("slot_index", ADDR_W'(want.slot_index),
                           ADDR_W'(rsp_mon.slot_index));
               check_field("block_address", want.block_address, rsp_mon.block_address);
               check_field("block_length", want.block_length, rsp_mon.block_length);
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            // The top only takes effect on the next reinitialize.
            if (csr_mon.reg_index == CSR_STREAM_TOP)
               top_reg = csr_mon.write_data;
            else if (csr_mon.reg_index == CSR_FLOOR_OFFSET)
               floor_reg = csr_mon.write_data;
         end
         if (req_mon.valid && req_mon.ready)
            awaited_results.push_back(predict_step(req_mon.cmd, req_mon.request_length,
                                                   req_mon.slot_id));
         error_count <= mismatches;
         outstanding <= awaited_results.size();
      end
   end

endmodule

FILE: tb/tb_stream_buffer_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Stream buffer slot allocator testbench
// Drives directed and random allocate, free, query and reinitialize requests
// through several register settings, with bursty requests and a stalling
// response side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_stream_buffer_slot_allocator_core;
   import sbsa_pkg::*;

   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 178;
   localparam int CYCLE_LIMIT     = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_ready = 1'b0;
   int   error_count;
   int   outstanding;
   int   cycle_count = 0;
   int   cmd_tally [4] = '{0, 0, 0, 0};
   int   stall_left;
   int   mode_age;
   int   ready_mode;

   sbsa_req_if req_bus ();
   sbsa_rsp_if rsp_bus ();
   sbsa_csr_if csr_bus ();

   assign rsp_bus.ready = rsp_ready;

   stream_buffer_slot_allocator_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sbsa_slot_table_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stream_buffer_slot_allocator_core verification failed");
         $finish;
      end
   end

   // Response side: always ready, randomly ready, or short ready pulses
   // followed by random stalls, with the mode redrawn at random periodically.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         mode_age   <= 0;
         ready_mode <= 0;
      end else begin
         if (mode_age == 599) begin
            mode_age   <= 0;
            ready_mode <= $urandom_range(0, 2);
         end else begin
            mode_age <= mode_age + 1;
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: begin
                  rsp_ready  <= 1'b1;
                  stall_left <= $urandom_range(0, 60);
               end
            endcase
         end
      end
   end

   // Holds valid high into the next call so back-to-back requests stay busy.
   task automatic send_item(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] len,
                            input logic [ID_W-1:0] id);
      req_bus.valid          <= 1'b1;
      req_bus.cmd            <= op;
      req_bus.request_length <= len;
      req_bus.slot_id        <= id;
      cmd_tally[op]++;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [ADDR_W-1:0] value);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= index;
      csr_bus.write_data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // The checker's count is registered, so wait for a clock edge before looking.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int                roll;
      int                gap;
      int                burst_left;
      logic [CMD_W-1:0]  op;
      logic [ADDR_W-1:0] len;
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] top_val;
      logic [ADDR_W-1:0] floor_val;

      req_bus.valid          <= 1'b0;
      req_bus.cmd            <= CMD_ALLOC;
      req_bus.request_length <= '0;
      req_bus.slot_id        <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.reg_index      <= CSR_STREAM_TOP;
      csr_bus.write_data     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset register values.
      send_item(CMD_QUERY,  25'd0, 8'd0);
      send_item(CMD_ALLOC,  25'd0, 8'd0);
      send_item(CMD_ALLOC,  25'd1, 8'd0);
      send_item(CMD_ALLOC,  25'd32, 8'd0);
      send_item(CMD_ALLOC,  25'd33, 8'd0);
      send_item(CMD_ALLOC,  25'h1FFFFFF, 8'd0);
      send_item(CMD_ALLOC,  25'd16777216, 8'd0);
      send_item(CMD_FREE,   25'd0, 8'd1);
      send_item(CMD_ALLOC,  25'd20, 8'd0);
      send_item(CMD_FREE,   25'd0, 8'd0);
      send_item(CMD_ALLOC,  25'd0, 8'd0);
      send_item(CMD_FREE,   25'd0, 8'd10);
      send_item(CMD_QUERY,  25'd0, 8'd10);
      send_item(CMD_QUERY,  25'd0, 8'd63);
      send_item(CMD_QUERY,  25'h1FFFFFF, 8'd64);
      send_item(CMD_FREE,   25'd0, 8'd255);
      send_item(CMD_FREE,   25'd0, 8'd3);
      send_item(CMD_ALLOC,  25'd40, 8'd0);
      send_item(CMD_FREE,   25'd0, 8'd3);
      send_item(CMD_ALLOC,  25'd10, 8'd0);
      send_item(CMD_QUERY,  25'd0, 8'd3);
      send_item(CMD_REINIT, 25'd0, 8'hFF);
      send_item(CMD_QUERY,  25'd0, 8'd1);
      // Carve exactly down to the floor, then one more byte cannot fit.
      send_item(CMD_ALLOC,  25'd16775936, 8'd0);
      send_item(CMD_ALLOC,  25'd1, 8'd0);
      send_item(CMD_REINIT, 25'd0, 8'd0);
      drain_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin top_val = 25'd16777216; floor_val = 25'd1280;       end
            1: begin top_val = 25'd0;        floor_val = 25'd0;          end
            2: begin top_val = 25'd4096;     floor_val = 25'd1024;       end
            3: begin top_val = 25'h1FFFFFF;  floor_val = 25'd16777216;   end
            4: begin top_val = 25'd1000;     floor_val = 25'd2000;       end
            5: begin
               top_val   = ADDR_W'($urandom());
               floor_val = ADDR_W'($urandom()) >> $urandom_range(4, 24);
            end
            6: begin top_val = 25'd16777215; floor_val = 25'd1;          end
            7: begin top_val = 25'd65536;    floor_val = 25'd32;         end
            default: begin top_val = 25'd12345678; floor_val = 25'h1FFFFFF; end
         endcase
         write_reg(CSR_STREAM_TOP, top_val);
         write_reg(CSR_FLOOR_OFFSET, floor_val);
         csr_bus.valid <= 1'b0;
         // The new top is loaded only by a reinitialize.
         send_item(CMD_REINIT, ADDR_W'($urandom()), ID_W'($urandom()));
         burst_left = $urandom_range(1, 16);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 199);
            if (roll == 0)
               op = CMD_REINIT;
            else if (roll < 96)
               op = CMD_ALLOC;
            else if (roll < 146)
               op = CMD_FREE;
            else
               op = CMD_QUERY;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: len = ADDR_W'($urandom_range(0, 1023));
               6, 7: len = ADDR_W'($urandom_range(0, 65535));
               8: len = ADDR_W'($urandom_range(0, 2047) * 32 + $urandom_range(0, 1));
               default: len = ADDR_W'($urandom());
            endcase
            if ($urandom_range(0, 6) != 0)
               id = ID_W'($urandom_range(0, SLOT_COUNT - 1));
            else
               id = ID_W'($urandom());
            send_item(op, len, id);
            if ($urandom_range(0, 149) == 0) begin
               // Let the block run completely empty now and then.
               drain_results();
               burst_left = $urandom_range(1, 16);
            end else if (burst_left > 1) begin
               burst_left--;
            end else begin
               gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70)
                                                 : $urandom_range(0, 3);
               if (gap != 0) begin
                  req_bus.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 16);
            end
         end
         drain_results();
      end

      repeat (SLOT_COUNT + 8) @(posedge clock);
      $display("Drove %0d requests: %0d allocate, %0d free, %0d query, %0d reinitialize.",
               cmd_tally[0] + cmd_tally[1] + cmd_tally[2] + cmd_tally[3],
               cmd_tally[CMD_ALLOC], cmd_tally[CMD_FREE], cmd_tally[CMD_QUERY],
               cmd_tally[CMD_REINIT]);
      $display("Covered %0d register settings, among them zero, full-range and floor above top.",
               PHASES);
      if (error_count == 0)
         $display("stream_buffer_slot_allocator_core verification clean");
      else
         $display("stream_buffer_slot_allocator_core verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/sbsa_pkg.sv
rtl/sbsa_if.sv
rtl/sbsa_cell.sv
rtl/stream_buffer_slot_allocator_core.sv
tb/sbsa_slot_table_checker.sv
tb/tb_stream_buffer_slot_allocator_core.sv
